### rtl/core/uqtd_pkg.sv
// shared types and constants for the url query tokenizer and decoder
// no dependencies; used by every module of the block
package uqtd_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_NAME      = 2'd0,
		KIND_VALUE     = 2'd1,
		KIND_PAIR_END  = 2'd2,
		KIND_QUERY_END = 2'd3
	} kind_t;

	// percent escape progress
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HIGH = 2'd2
	} esc_t;

	// configuration register indexes
	localparam logic REG_DECODE_ENABLE = 1'b0;
	localparam logic REG_MAX_PAIRS     = 1'b1;

	localparam logic       DECODE_ENABLE_RST = 1'b1;
	localparam logic [7:0] PAIR_LIMIT        = 8'd16;

	// delimiter and escape characters
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// one transaction can cause this many results
	localparam int MAX_RES  = 4;
	localparam int RIDX_W   = $clog2(MAX_RES);
	localparam int RCNT_W   = $clog2(MAX_RES + 1);

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [7:0] pnum;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [RCNT_W-1:0]     cnt;
		res_t [MAX_RES-1:0]    res;
	} bundle_t;

	// write side of the queue
	typedef struct packed {
		logic    push;
		bundle_t data;
	} qwr_t;

endpackage

### rtl/core/uqtd_front.sv
// front end: configuration registers, tokenizer state and per-byte classification
// builds the bundle of results caused by each input transaction; uses uqtd_pkg
module uqtd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           query_byte,
	input  logic                 end_of_query,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_wdata,
	output uqtd_pkg::qwr_t       qwr
);

	typedef struct packed {
		uqtd_pkg::esc_t esc;
		logic [3:0]     hi;
		logic           inval;
		logic [7:0]     pairs;
		logic           phb;
		logic           trunc;
		logic           stop;
	} fstate_t;

	typedef struct packed {
		fstate_t                                     st;
		logic [uqtd_pkg::RCNT_W-1:0]                 cnt;
		uqtd_pkg::res_t [uqtd_pkg::MAX_RES-1:0]      res;
	} ctx_t;

	fstate_t    state_q;
	fstate_t    state_nxt;
	logic       decode_en_q;
	logic [7:0] max_pairs_q;

	function automatic logic [4:0] hex_val(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic ctx_t emit(ctx_t c, uqtd_pkg::kind_t k, logic [7:0] ch,
		logic [7:0] pn, logic last);
		ctx_t r;
		r = c;
		if (r.cnt < uqtd_pkg::RCNT_W'(uqtd_pkg::MAX_RES)) begin
			r.res[r.cnt[uqtd_pkg::RIDX_W-1:0]] = '{kind: k, ch: ch, pnum: pn, last: last};
			r.cnt = r.cnt + uqtd_pkg::RCNT_W'(1);
		end
		return r;
	endfunction

	function automatic ctx_t put_char(ctx_t c, logic [7:0] ch);
		ctx_t            r;
		uqtd_pkg::kind_t k;
		r = c;
		k = uqtd_pkg::KIND_NAME;
		if (r.st.inval) begin
			k = uqtd_pkg::KIND_VALUE;
		end
		if (!r.st.trunc) begin
			if (ch == 8'd0) begin
				r.st.trunc = 1'b1;
			end else begin
				r = emit(r, k, ch, r.st.pairs, 1'b0);
			end
		end
		return r;
	endfunction

	function automatic ctx_t flush_field(ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.esc == uqtd_pkg::ESC_HIGH) begin
			r = put_char(r, {r.st.hi, 4'h0});
		end
		r.st.esc   = uqtd_pkg::ESC_NONE;
		r.st.hi    = 4'h0;
		r.st.trunc = 1'b0;
		return r;
	endfunction

	function automatic ctx_t close_pair(ctx_t c);
		ctx_t r;
		r = flush_field(c);
		r = emit(r, uqtd_pkg::KIND_PAIR_END, 8'd0, r.st.pairs, 1'b0);
		if (r.st.pairs != 8'hFF) begin
			r.st.pairs = r.st.pairs + 8'd1;
		end
		r.st.phb   = 1'b0;
		r.st.inval = 1'b0;
		return r;
	endfunction

	function automatic ctx_t field_byte(ctx_t c, logic [7:0] b, logic dec);
		ctx_t       r;
		logic [4:0] hv;
		logic       done;
		r    = c;
		hv   = hex_val(b);
		done = 1'b0;
		if (!r.st.trunc) begin
			if (r.st.esc == uqtd_pkg::ESC_PCT) begin
				r.st.esc = uqtd_pkg::ESC_NONE;
				if (hv[4]) begin
					r.st.hi  = hv[3:0];
					r.st.esc = uqtd_pkg::ESC_HIGH;
				end else begin
					r.st.trunc = 1'b1;
				end
			end else begin
				if (r.st.esc == uqtd_pkg::ESC_HIGH) begin
					r.st.esc = uqtd_pkg::ESC_NONE;
					if (hv[4]) begin
						r    = put_char(r, {r.st.hi, hv[3:0]});
						done = 1'b1;
					end else begin
						// high digit followed by a non-hex byte
						r = put_char(r, {r.st.hi, 4'h0});
						done = r.st.trunc;
					end
				end
				if (!done) begin
					if (dec && b == uqtd_pkg::CH_PLUS) begin
						r = put_char(r, uqtd_pkg::CH_SPACE);
					end else if (dec && b == uqtd_pkg::CH_PCT) begin
						r.st.esc = uqtd_pkg::ESC_PCT;
					end else begin
						r = put_char(r, b);
					end
				end
			end
		end
		return r;
	endfunction

	always_comb begin
		ctx_t cx;
		logic is_end;
		cx.st  = state_q;
		cx.cnt = '0;
		cx.res = '0;
		is_end = end_of_query || (query_byte == 8'd0);

		if (query_byte != 8'd0 && !cx.st.stop) begin
			if (!cx.st.phb) begin
				if (cx.st.pairs >= max_pairs_q) begin
					cx.st.stop = 1'b1;
				end else begin
					cx.st.phb   = 1'b1;
					cx.st.inval = 1'b0;
				end
			end
			if (cx.st.phb) begin
				if (query_byte == uqtd_pkg::CH_AMP) begin
					cx = close_pair(cx);
				end else if (query_byte == uqtd_pkg::CH_EQ && !cx.st.inval) begin
					cx          = flush_field(cx);
					cx.st.inval = 1'b1;
				end else begin
					cx = field_byte(cx, query_byte, decode_en_q);
				end
			end
		end

		if (is_end) begin
			if (cx.st.phb) begin
				cx = close_pair(cx);
			end
			cx    = emit(cx, uqtd_pkg::KIND_QUERY_END, 8'd0, cx.st.pairs, 1'b1);
			cx.st = '0;
		end

		state_nxt     = cx.st;
		qwr.push      = accept && (cx.cnt != '0);
		qwr.data.cnt  = cx.cnt;
		qwr.data.res  = cx.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_en_q <= uqtd_pkg::DECODE_ENABLE_RST;
			max_pairs_q <= uqtd_pkg::PAIR_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uqtd_pkg::REG_DECODE_ENABLE: decode_en_q <= cfg_wdata[0];
				uqtd_pkg::REG_MAX_PAIRS:     max_pairs_q <= cfg_wdata;
				default:                     max_pairs_q <= max_pairs_q;
			endcase
		end
	end

endmodule

### rtl/core/uqtd_queue.sv
// short bundle queue between the front and back ends
// register-based, single read port at the head; uses uqtd_pkg
module uqtd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  uqtd_pkg::qwr_t    qwr,
	input  logic              pop,
	output uqtd_pkg::bundle_t head,
	output logic              empty,
	output logic              full
);

	uqtd_pkg::bundle_t             mem_q [uqtd_pkg::QUEUE_DEPTH];
	logic [uqtd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [uqtd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [uqtd_pkg::QPTR_W:0]     count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == (uqtd_pkg::QPTR_W+1)'(uqtd_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem_q[wr_ptr_q] <= qwr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= wr_ptr_q + uqtd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + uqtd_pkg::QPTR_W'(1);
			end
			if (qwr.push && !pop) begin
				count_q <= count_q + (uqtd_pkg::QPTR_W+1)'(1);
			end else if (pop && !qwr.push) begin
				count_q <= count_q - (uqtd_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

### rtl/core/uqtd_back.sv
// back end: walks the results of the head bundle into the output register
// one result per cycle unless out_stall holds the output register; uses uqtd_pkg
module uqtd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  uqtd_pkg::bundle_t head,
	input  logic              empty,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output uqtd_pkg::res_t    out_res
);

	logic [uqtd_pkg::RIDX_W-1:0] idx_q;
	logic                        out_valid_q;
	uqtd_pkg::res_t              out_res_q;
	logic                        load;
	logic                        last_of_bundle;

	assign load           = !empty && (!out_valid_q || !out_stall);
	assign last_of_bundle = ({1'b0, idx_q} + uqtd_pkg::RCNT_W'(1)) == head.cnt;
	assign pop            = load && last_of_bundle;
	assign out_valid      = out_valid_q;
	assign out_res        = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_of_bundle ? '0 : idx_q + uqtd_pkg::RIDX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= head.res[idx_q];
		end
	end

endmodule

### rtl/core/url_query_tokenizer_decoder.sv
// url query tokenizer and percent decoder, top level; uses uqtd_pkg, uqtd_front,
// uqtd_queue and uqtd_back. results pass the queue, then the output register. throughput:
// one input byte per cycle with out_stall low and each byte yielding at most one result;
// a byte yielding k results (up to four) holds the single output register until all k are
// out. the four-entry bundle queue absorbs bursts; input stalls only when it is full.
// reset: asynchronous, clears tokenizer state and queue, decode_enable=1, max_pairs=16.
module url_query_tokenizer_decoder (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] query_byte,
	input  logic       end_of_query,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] token_kind,
	output logic [7:0] char_out,
	output logic [7:0] pair_number,
	output logic       last_result,
	// configuration write port
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	uqtd_pkg::qwr_t    qwr;
	uqtd_pkg::bundle_t q_head;
	uqtd_pkg::res_t    out_res;
	logic              q_empty;
	logic              q_full;
	logic              q_pop;
	logic              in_accept;

	// input transaction goes through whenever the queue has room
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	// front: classify each byte and build its result bundle combinationally
	uqtd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.query_byte   (query_byte),
		.end_of_query (end_of_query),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.qwr          (qwr)
	);

	// bundles with no results never enter the queue
	uqtd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// back: serialize bundle results into the output register
	uqtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign token_kind  = out_res.kind;
	assign char_out    = out_res.ch;
	assign pair_number = out_res.pnum;
	assign last_result = out_res.last;

	// queue never written while full
	assert property (@(posedge clk) disable iff (!arst_n) qwr.push |-> !q_full)
		else $error("bundle pushed into full queue");

	// an empty bundle is never queued
	assert property (@(posedge clk) disable iff (!arst_n) qwr.push |-> (qwr.data.cnt != '0))
		else $error("empty bundle pushed");

	// last flag goes with the query-end kind only
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (token_kind == uqtd_pkg::KIND_QUERY_END)))
		else $error("last_result does not match query-end kind");

	// marker results carry no character
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind == uqtd_pkg::KIND_PAIR_END ||
			token_kind == uqtd_pkg::KIND_QUERY_END)) |-> (char_out == 8'd0))
		else $error("marker result carries a character");

endmodule
